// ----- hw/rtl/sliding_window_byte_quota_macros.svh -----
// Assertion macros shared by the byte quota RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef SLIDING_WINDOW_BYTE_QUOTA_MACROS_SVH
`define SLIDING_WINDOW_BYTE_QUOTA_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SWBQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SWBQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/swbq_pkg.sv -----
// Shared constants and types for the sliding window byte quota block.
// No dependencies; imported by the controller, datapath and top level.
package swbq_pkg;

  localparam int HISTORY_DEPTH = 16;
  localparam int PTR_W         = $clog2(HISTORY_DEPTH);

  localparam int TIME_W   = 48;
  localparam int BYTES_W  = 31;
  localparam int WINDOW_W = 20;
  localparam int SUM_W    = BYTES_W + PTR_W;
  localparam int WORD_W   = TIME_W + BYTES_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMIT_ENABLED = 2'd0,
    CFG_WINDOW_MS     = 2'd1,
    CFG_QUOTA_BYTES   = 2'd2
  } swbq_cfg_idx_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic decide;
  } swbq_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic enabled;
    logic scan_last;
  } swbq_status_t;

endpackage

// ----- hw/rtl/swbq_dpath.sv -----
// Datapath: configuration, grant ring memory, scan accumulators and result registers.
// Depends on swbq_pkg and sliding_window_byte_quota_macros.svh.
`include "sliding_window_byte_quota_macros.svh"

module swbq_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [swbq_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
  input  logic [swbq_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  input  logic [swbq_pkg::TIME_W-1:0]   now_ms,
  input  logic [swbq_pkg::BYTES_W-1:0]  expect_bytes,
  input  swbq_pkg::swbq_cmd_t          cmd,
  output swbq_pkg::swbq_status_t       status,
  output logic [swbq_pkg::BYTES_W-1:0]  granted_bytes,
  output logic                         must_wait,
  output logic [swbq_pkg::WINDOW_W-1:0] wait_ms,
  output logic                         done
);
  import swbq_pkg::*;

  logic                cfg_enabled;
  logic [WINDOW_W-1:0] cfg_window;
  logic [BYTES_W-1:0]  cfg_quota;
  logic                cfg_hit;

  logic [TIME_W-1:0]   now_q;
  logic [BYTES_W-1:0]  expect_q;

  logic [WORD_W-1:0]   mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] entry_valid;
  logic [PTR_W-1:0]    write_ptr;
  logic [PTR_W-1:0]    scan_idx;

  logic [WORD_W-1:0]   rd_word;
  logic                rd_valid;
  logic [PTR_W-1:0]    rd_idx;
  logic                eval_pend;

  logic [SUM_W-1:0]    sum;
  logic [WINDOW_W-1:0] oldest_age;
  logic                any_live;

  logic [TIME_W-1:0]   age;
  logic                live;
  logic                exhausted;
  logic [BYTES_W-1:0]  remain;
  logic [BYTES_W-1:0]  amount;
  logic                slot_full;
  logic                mem_we;

  // Decode configuration writes; an unknown index changes nothing
  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_wr_en) begin
      unique case (cfg_wr_index)
        CFG_LIMIT_ENABLED, CFG_WINDOW_MS, CFG_QUOTA_BYTES: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_enabled <= 1'b0;
      cfg_window  <= WINDOW_W'(1);
      cfg_quota   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_wr_index)
        CFG_LIMIT_ENABLED: cfg_enabled <= cfg_wr_data[0];
        CFG_WINDOW_MS:     cfg_window  <= cfg_wr_data[WINDOW_W-1:0];
        CFG_QUOTA_BYTES:   cfg_quota   <= cfg_wr_data[BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // Age test of the entry read in the previous cycle
  always_comb begin
    age  = now_q - rd_word[WORD_W-1:BYTES_W];
    live = rd_valid && (age < {{(TIME_W-WINDOW_W){1'b0}}, cfg_window});
  end

  // Quota decision on the finished sum
  always_comb begin
    exhausted = ({{(SUM_W-BYTES_W){1'b0}}, cfg_quota} <= sum);
    remain    = cfg_quota - sum[BYTES_W-1:0];
    amount    = (remain > expect_q) ? expect_q : remain;
    slot_full = entry_valid[write_ptr];
    mem_we    = cmd.decide && cfg_enabled && !exhausted && !slot_full;
  end

  // Latch the request item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_q    <= now_ms;
      expect_q <= expect_bytes;
    end
  end

  // Ring memory: one read and one write port, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[write_ptr] <= {now_q, amount};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_word <= mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= entry_valid[scan_idx];
    rd_idx   <= scan_idx;
  end

  // Scan pointer and evaluation stage flag
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx  <= '0;
      eval_pend <= 1'b0;
    end else begin
      eval_pend <= cmd.issue;
      if (cmd.load) begin
        scan_idx <= '0;
      end else if (cmd.issue) begin
        scan_idx <= scan_idx + PTR_W'(1);
      end
    end
  end

  // Valid bits and write pointer: clear on config, drop expired, set on record
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      entry_valid <= '0;
      write_ptr   <= '0;
    end else begin
      if (eval_pend && rd_valid && !live) begin
        entry_valid[rd_idx] <= 1'b0;
      end
      if (mem_we) begin
        entry_valid[write_ptr] <= 1'b1;
        write_ptr <= (write_ptr == PTR_W'(HISTORY_DEPTH-1)) ? '0 : write_ptr + PTR_W'(1);
      end
    end
  end

  // Accumulate live amounts and track the oldest live age
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sum        <= '0;
      oldest_age <= '0;
      any_live   <= 1'b0;
    end else if (eval_pend && live) begin
      sum <= sum + {{(SUM_W-BYTES_W){1'b0}}, rd_word[BYTES_W-1:0]};
      if (!any_live || age[WINDOW_W-1:0] > oldest_age) begin
        oldest_age <= age[WINDOW_W-1:0];
      end
      any_live <= 1'b1;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      if (!cfg_enabled || (!exhausted && slot_full)) begin
        granted_bytes <= expect_q;
        must_wait     <= 1'b0;
        wait_ms       <= '0;
      end else if (exhausted) begin
        granted_bytes <= '0;
        must_wait     <= 1'b1;
        wait_ms       <= any_live ? cfg_window - oldest_age : cfg_window;
      end else begin
        granted_bytes <= amount;
        must_wait     <= 1'b0;
        wait_ms       <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.decide;
    end
  end

  assign status.enabled   = cfg_enabled;
  assign status.scan_last = (scan_idx == PTR_W'(HISTORY_DEPTH-1));

  `SWBQ_ASSERT_NEXT(a_decide_strobes, cmd.decide, done, "result strobe missing after decide")
  `SWBQ_ASSERT_NOW(a_wait_grants_none, done && must_wait, granted_bytes == '0,
                   "wait result with nonzero grant")
  `SWBQ_ASSERT_NOW(a_grant_no_wait, done && !must_wait, wait_ms == '0,
                   "grant result with nonzero wait time")

endmodule

// ----- hw/rtl/swbq_ctrl.sv -----
// Controller state machine: sequences load, ring scan and decision for one item.
// Depends on swbq_pkg.
module swbq_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  swbq_pkg::swbq_status_t status,
  output swbq_pkg::swbq_cmd_t    cmd,
  output logic                   busy
);
  import swbq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_FINAL  = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = status.enabled ? S_SCAN : S_DECIDE;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (status.scan_last) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ----- hw/rtl/sliding_window_byte_quota.sv -----
// Sliding window byte quota: top level joining controller and datapath.
// Enforced item: after start is taken the controller scans the ring, one ring read per cycle,
// then passes a final state and the decide state; the result strobe is registered after decide.
// Pass-through item (quota off): load goes straight to decide; the next item is taken once idle.
// Reset: quota off, window 1 ms, quota 0, ring empty. Results cannot be stalled.
module sliding_window_byte_quota (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cfg_wr_en,
  input  logic [swbq_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
  input  logic [swbq_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
  input  logic [swbq_pkg::TIME_W-1:0]      now_ms,
  input  logic [swbq_pkg::BYTES_W-1:0]     expect_bytes,
  output logic                             done,
  output logic [swbq_pkg::BYTES_W-1:0]     granted_bytes,
  output logic                             must_wait,
  output logic [swbq_pkg::WINDOW_W-1:0]    wait_ms
);
  import swbq_pkg::*;

  swbq_cmd_t    cmd;
  swbq_status_t status;

  swbq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  swbq_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_index  (cfg_wr_index),
    .cfg_wr_data   (cfg_wr_data),
    .now_ms        (now_ms),
    .expect_bytes  (expect_bytes),
    .cmd           (cmd),
    .status        (status),
    .granted_bytes (granted_bytes),
    .must_wait     (must_wait),
    .wait_ms       (wait_ms),
    .done          (done)
  );

endmodule

// ----- tb/sv/swbq_quota_checker.sv -----
// Checker for the sliding window byte quota: shadows the registers and the grant ring,
// predicts each item's verdict and compares it with the result strobe.
// Depends on swbq_pkg for widths, ring depth and register indexes.
module swbq_quota_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic                            cfg_wr_en,
  input  logic [swbq_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
  input  logic [swbq_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  input  logic [swbq_pkg::TIME_W-1:0]     now_ms,
  input  logic [swbq_pkg::BYTES_W-1:0]    expect_bytes,
  input  logic                            done,
  input  logic [swbq_pkg::BYTES_W-1:0]    granted_bytes,
  input  logic                            must_wait,
  input  logic [swbq_pkg::WINDOW_W-1:0]   wait_ms,
  output int                              pending_results,
  output int                              fail_count
);
  import swbq_pkg::*;

  typedef struct packed {
    logic [BYTES_W-1:0]  granted_bytes;
    logic                must_wait;
    logic [WINDOW_W-1:0] wait_ms;
  } quota_verdict_t;

  // Shadow registers
  logic                quota_on;
  logic [WINDOW_W-1:0] window_len;
  logic [BYTES_W-1:0]  quota_len;

  // Shadow grant ring
  logic [TIME_W-1:0]   grant_stamp [HISTORY_DEPTH];
  logic [BYTES_W-1:0]  grant_size  [HISTORY_DEPTH];
  logic                live        [HISTORY_DEPTH];
  logic [PTR_W-1:0]    next_slot;

  quota_verdict_t verdicts_due[$];
  quota_verdict_t due;

  function automatic void clear_history();
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      grant_stamp[i] = '0;
      grant_size[i]  = '0;
      live[i]        = 1'b0;
    end
    next_slot = '0;
  endfunction

  // Expire stale grants, sum the live ones, then grant, refuse or pass through
  function automatic quota_verdict_t judge_request(input logic [TIME_W-1:0]  t,
                                                   input logic [BYTES_W-1:0] want);
    quota_verdict_t     v;
    logic [TIME_W-1:0]  age;
    logic [TIME_W-1:0]  oldest;
    logic [SUM_W-1:0]   total;
    logic [BYTES_W-1:0] remain;
    logic [BYTES_W-1:0] share;
    logic               any_live;
    v.granted_bytes = want;
    v.must_wait     = 1'b0;
    v.wait_ms       = '0;
    if (!quota_on) return v;
    total    = '0;
    oldest   = '0;
    any_live = 1'b0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (live[i]) begin
        // age wraps modulo 2^48, so a grant from the future looks ancient
        age = t - grant_stamp[i];
        if (age < TIME_W'(window_len)) begin
          total += SUM_W'(grant_size[i]);
          if (!any_live || age > oldest) oldest = age;
          any_live = 1'b1;
        end else begin
          live[i] = 1'b0;
        end
      end
    end
    if (SUM_W'(quota_len) <= total) begin
      v.granted_bytes = '0;
      v.must_wait     = 1'b1;
      v.wait_ms       = any_live ? window_len - oldest[WINDOW_W-1:0] : window_len;
      return v;
    end
    remain = quota_len - total[BYTES_W-1:0];
    share  = (remain > want) ? want : remain;
    // ring full: pass the whole request and record nothing
    if (live[next_slot]) return v;
    grant_stamp[next_slot] = t;
    grant_size[next_slot]  = share;
    live[next_slot]        = 1'b1;
    next_slot              = next_slot + PTR_W'(1);
    v.granted_bytes        = share;
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      quota_on   = 1'b0;
      window_len = WINDOW_W'(1);
      quota_len  = '0;
      clear_history();
      verdicts_due.delete();
      pending_results = 0;
      fail_count      = 0;
    end else begin
      // Compare the strobed result with the oldest prediction
      if (done) begin
        if (verdicts_due.size() == 0) begin
          $error("result strobe with no item outstanding");
          fail_count++;
        end else begin
          due = verdicts_due.pop_front();
          if (granted_bytes !== due.granted_bytes) begin
            $error("granted_bytes: expected %0d, got %0d", due.granted_bytes, granted_bytes);
            fail_count++;
          end
          if (must_wait !== due.must_wait) begin
            $error("must_wait: expected %0d, got %0d", due.must_wait, must_wait);
            fail_count++;
          end
          if (wait_ms !== due.wait_ms) begin
            $error("wait_ms: expected %0d, got %0d", due.wait_ms, wait_ms);
            fail_count++;
          end
        end
      end
      // Track register writes; a write to a known register empties the ring
      if (cfg_wr_en) begin
        case (cfg_wr_index)
          CFG_LIMIT_ENABLED: begin
            quota_on = cfg_wr_data[0];
            clear_history();
          end
          CFG_WINDOW_MS: begin
            window_len = cfg_wr_data[WINDOW_W-1:0];
            clear_history();
          end
          CFG_QUOTA_BYTES: begin
            quota_len = cfg_wr_data[BYTES_W-1:0];
            clear_history();
          end
          default: ;
        endcase
      end
      // Predict each accepted item
      if (start && !busy) verdicts_due.push_back(judge_request(now_ms, expect_bytes));
      pending_results = verdicts_due.size();
    end
  end

endmodule

// ----- tb/sv/tb_sliding_window_byte_quota.sv -----
// Testbench top for the sliding window byte quota: clock, reset, directed and random
// requests with random gaps, register phases, verdict. Depends on swbq_pkg, the block
// and swbq_quota_checker.
module tb_sliding_window_byte_quota;
  import swbq_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX  = 2'd3;
  localparam logic [BYTES_W-1:0]   BYTES_MAX      = '1;
  localparam logic [WINDOW_W-1:0]  WINDOW_MAX     = '1;
  localparam logic [TIME_W-1:0]    TIME_MAX       = '1;
  localparam int                   RANDOM_PHASES  = 14;
  localparam int                   ITEMS_PER_HALF = 66;
  localparam int                   CYCLE_LIMIT    = 400000;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  start         = 1'b0;
  logic                  busy;
  logic                  cfg_wr_en     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_wr_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data   = '0;
  logic [TIME_W-1:0]     now_ms        = '0;
  logic [BYTES_W-1:0]    expect_bytes  = '0;
  logic                  done;
  logic [BYTES_W-1:0]    granted_bytes;
  logic                  must_wait;
  logic [WINDOW_W-1:0]   wait_ms;
  int                    pending_results;
  int                    fail_count;
  int                    cycle_count   = 0;
  int unsigned           no_gap_run    = 0;

  sliding_window_byte_quota dut (
    .clk, .rst, .start, .busy, .cfg_wr_en, .cfg_wr_index, .cfg_wr_data,
    .now_ms, .expect_bytes, .done, .granted_bytes, .must_wait, .wait_ms
  );

  swbq_quota_checker u_quota_checker (
    .clk, .rst, .start, .busy, .cfg_wr_en, .cfg_wr_index, .cfg_wr_data,
    .now_ms, .expect_bytes, .done, .granted_bytes, .must_wait, .wait_ms,
    .pending_results, .fail_count
  );

  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Hold off a random number of cycles, then present the item until it is taken
  task automatic issue_request(input logic [TIME_W-1:0] t, input logic [BYTES_W-1:0] b);
    int unsigned gap;
    if (no_gap_run > 0) begin
      gap = 0;
      no_gap_run--;
    end else begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 24) == 0) no_gap_run = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        = 1'b1;
    now_ms       = t;
    expect_bytes = b;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  // Drop start and let every outstanding result drain
  task automatic wait_idle();
    start = 1'b0;
    while (pending_results != 0 || busy) @(negedge clk);
  endtask

  // Write one register once nothing is in flight
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_wr_en    = 1'b1;
    cfg_wr_index = idx;
    cfg_wr_data  = data;
    @(negedge clk);
    cfg_wr_en    = 1'b0;
    @(negedge clk);
  endtask

  // Write all three registers; unused upper data bits carry noise
  task automatic set_config(input logic en, input logic [WINDOW_W-1:0] win,
                            input logic [BYTES_W-1:0] quota);
    logic [31:0] noise;
    noise = $urandom;
    write_cfg(CFG_LIMIT_ENABLED, {noise[29:0], en});
    write_cfg(CFG_WINDOW_MS, {noise[10:0], win});
    write_cfg(CFG_QUOTA_BYTES, quota);
  endtask

  initial begin
    logic [TIME_W-1:0]   cur_time;
    logic [BYTES_W-1:0]  want;
    logic [WINDOW_W-1:0] win;
    logic [BYTES_W-1:0]  quota;
    logic                en;
    int unsigned         step_max;
    int unsigned         byte_max;
    int unsigned         pick;

    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Pass-through after reset at the field extremes
    issue_request('0, BYTES_MAX);
    issue_request(TIME_MAX, '0);
    // Quota of zero with nothing live: wait the whole window
    write_cfg(CFG_LIMIT_ENABLED, '1);
    issue_request(48'd100, 31'd5);
    // Zero window: nothing ever live
    write_cfg(CFG_WINDOW_MS, '0);
    issue_request(48'd200, 31'd5);
    write_cfg(CFG_QUOTA_BYTES, 31'd100);
    issue_request(48'd300, 31'd40);
    issue_request(48'd300, 31'd100);
    // Partial grant, exhaustion, expiry at the window edge, time going backwards
    write_cfg(CFG_WINDOW_MS, {11'h7ff, 20'd1000});
    issue_request(48'd1000, 31'd60);
    issue_request(48'd1010, 31'd60);
    issue_request(48'd1020, 31'd5);
    issue_request(48'd2000, 31'd100);
    issue_request(48'd500, 31'd100);
    // Time wrapping past the top keeps the grant live
    issue_request(TIME_MAX - 48'd4, 31'd10);
    issue_request(48'd3, 31'd200);
    // Largest window and quota, request the whole quota
    wait_idle();
    set_config(1'b1, WINDOW_MAX, BYTES_MAX);
    issue_request(48'd0, BYTES_MAX);
    issue_request(48'd5, 31'd1);
    // Write to the unused index leaves the ring alone
    wait_idle();
    write_cfg(CFG_SPARE_IDX, '1);
    issue_request(48'd6, 31'd1);
    wait_idle();

    // Random phases, one register setting each
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 3))
        0:       cur_time = '0;
        1:       cur_time = TIME_MAX - TIME_W'($urandom_range(0, 20000));
        default: cur_time = TIME_W'({$urandom, $urandom});
      endcase
      case (phase % 7)
        0: begin
          en = 1'b0; win = WINDOW_W'($urandom); quota = BYTES_W'($urandom);
          step_max = 1000; byte_max = 32'(BYTES_MAX);
        end
        1: begin
          // fill the ring and keep it full
          en = 1'b1; win = WINDOW_MAX; quota = BYTES_MAX;
          step_max = 3; byte_max = 1000;
        end
        2: begin
          en = 1'b1; win = '0;
          quota = ($urandom_range(0, 1) != 0) ? '0 : BYTES_W'($urandom_range(1, 5000));
          step_max = 50; byte_max = 2000;
        end
        3: begin
          // tight quota so grants run out and expire regularly
          en = 1'b1; win = WINDOW_W'($urandom_range(10, 500));
          quota = BYTES_W'($urandom_range(100, 5000));
          step_max = win / 8; byte_max = quota / 3 + 1;
        end
        4: begin
          en = 1'b1; win = WINDOW_W'(1); quota = BYTES_W'($urandom_range(1, 1000));
          step_max = 1; byte_max = 400;
        end
        5: begin
          en = 1'b1; win = WINDOW_W'($urandom_range(1, WINDOW_MAX)); quota = '0;
          step_max = 100; byte_max = 1000;
        end
        default: begin
          en = 1'b1; win = WINDOW_W'($urandom); quota = BYTES_W'($urandom);
          step_max = 32'(win); byte_max = 32'(BYTES_MAX);
        end
      endcase
      set_config(en, win, quota);
      for (int half = 0; half < 2; half++) begin
        if (half == 1) begin
          wait_idle();
          write_cfg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
        end
        for (int k = 0; k < ITEMS_PER_HALF; k++) begin
          // Advance time mostly in small steps, now and then jump or step back
          pick = $urandom_range(0, 99);
          if (pick == 0)
            cur_time = cur_time - TIME_W'($urandom_range(1, 5000));
          else if (pick < 4)
            cur_time = cur_time + TIME_W'($urandom_range(0, 2 * win + 10));
          else
            cur_time = cur_time + TIME_W'($urandom_range(0, step_max));
          case ($urandom_range(0, 19))
            0:       want = '0;
            1:       want = BYTES_W'($urandom);
            2:       want = BYTES_MAX;
            default: want = BYTES_W'($urandom_range(0, byte_max));
          endcase
          issue_request(cur_time, want);
        end
      end
      wait_idle();
    end

    // Drain and give the verdict
    wait_idle();
    repeat (HISTORY_DEPTH + 4) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
